/* rtl/doppler_frequency_interpolator_top_macros.svh */
// Assertion macros shared by the doppler frequency interpolator RTL.
`ifndef DOPPLER_FREQUENCY_INTERPOLATOR_TOP_MACROS_SVH
`define DOPPLER_FREQUENCY_INTERPOLATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define DFI_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define DFI_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/dfi_pkg.sv */
// Types, widths and codes shared by the doppler frequency interpolator.
`default_nettype none
package dfi_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int MODE_W      = 2;
   localparam int OFFSET_W    = 42;
   localparam int FREQ_W      = 33;
   localparam int STATUS_W    = 3;
   localparam int POINTS_W    = 7;
   localparam int ELAPSED_W   = OFFSET_W + 1;
   localparam int NUM_W       = OFFSET_W + 2;
   localparam int SPAN_W      = OFFSET_W;

   // multiply-divide sequencer
   localparam int DIV_STEPS   = FREQ_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   // register port
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = OFFSET_W;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLBACK   = 2'd1;

   // limits and reset values
   localparam logic [FREQ_W-1:0]   FREQ_MIN       = FREQ_W'(64'd70_000_000);
   localparam logic [FREQ_W-1:0]   FREQ_MAX       = FREQ_W'(64'd6_000_000_000);
   localparam logic [OFFSET_W-1:0] START_MAX      = OFFSET_W'(64'd4_102_444_800_000);
   localparam logic [FREQ_W-1:0]   FALLBACK_RESET = FREQ_W'(64'd145_800_000);

   // request modes
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_TABLE    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FALLBACK = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_STORED   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 3'd5;

   // one breakpoint as stored in the table memory
   typedef struct packed {
      logic signed [OFFSET_W-1:0] point_ms;
      logic [FREQ_W-1:0]          point_hz;
   } entry_type;

   // command to the multiply-divide unit
   typedef struct packed {
      logic              start;
      logic [FREQ_W-1:0] a;
      logic [SPAN_W-1:0] num;
      logic [SPAN_W-1:0] span;
   } div_in_type;

   // result from the multiply-divide unit
   typedef struct packed {
      logic              done;
      logic [FREQ_W-1:0] q;
      logic [SPAN_W-1:0] r;
   } div_out_type;

endpackage
`default_nettype wire

/* rtl/dfi_table_mem.sv */
// Breakpoint table memory: one write port, one registered read port.
`default_nettype none
module dfi_table_mem (
   input  wire                            clock,
   input  wire                            wr_en,
   input  wire  [dfi_pkg::ADDR_W-1:0]     wr_addr,
   input  dfi_pkg::entry_type             wr_data,
   input  wire                            rd_en,
   input  wire  [dfi_pkg::ADDR_W-1:0]     rd_addr,
   output dfi_pkg::entry_type             rd_data
);

   dfi_pkg::entry_type entry_mem [dfi_pkg::TABLE_DEPTH];
   dfi_pkg::entry_type rd_data_ff;

   // write one breakpoint
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/dfi_muldiv.sv */
// Serial multiply-divide: q = floor(a * num / span), r = remainder.
`default_nettype none
module dfi_muldiv (
   input  wire                   clock,
   input  wire                   reset,
   input  dfi_pkg::div_in_type   div_in,
   output dfi_pkg::div_out_type  div_out
);

   localparam logic [dfi_pkg::STEP_W-1:0] STEP_LAST = dfi_pkg::STEP_W'(dfi_pkg::DIV_STEPS - 1);

   logic                          busy_ff;
   logic                          phase_ff;
   logic                          done_ff;
   logic [dfi_pkg::STEP_W-1:0]    cnt_ff;
   logic [dfi_pkg::FREQ_W-1:0]    a_ff;
   logic [dfi_pkg::SPAN_W-1:0]    num_ff;
   logic [dfi_pkg::SPAN_W-1:0]    span_ff;
   logic [dfi_pkg::SPAN_W-1:0]    rr_ff;
   logic [dfi_pkg::FREQ_W-1:0]    qq_ff;

   logic [dfi_pkg::SPAN_W:0]      span_ext;
   logic [dfi_pkg::SPAN_W:0]      shifted;
   logic [dfi_pkg::SPAN_W:0]      shifted_sub;
   logic                          shifted_ge;
   logic [dfi_pkg::SPAN_W:0]      sum;
   logic [dfi_pkg::SPAN_W:0]      sum_sub;
   logic                          sum_ge;

   // doubling half-step and adding half-step of the remainder
   assign span_ext    = {1'b0, span_ff};
   assign shifted     = {rr_ff, 1'b0};
   assign shifted_sub = shifted - span_ext;
   assign shifted_ge  = (shifted >= span_ext);
   assign sum         = {1'b0, rr_ff} + {1'b0, num_ff};
   assign sum_sub     = sum - span_ext;
   assign sum_ge      = (sum >= span_ext);

   // sequence control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_in.start) begin
            busy_ff  <= 1'b1;
            phase_ff <= 1'b0;
            cnt_ff   <= '0;
         end else if (busy_ff) begin
            phase_ff <= ~phase_ff;
            if (phase_ff) begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == STEP_LAST) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

   // datapath: one multiplier bit per doubling and adding half-step pair, most significant first
   always_ff @(posedge clock) begin
      if (div_in.start) begin
         a_ff    <= div_in.a;
         num_ff  <= div_in.num;
         span_ff <= div_in.span;
         rr_ff   <= '0;
         qq_ff   <= '0;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            rr_ff <= shifted_ge ? shifted_sub[dfi_pkg::SPAN_W-1:0]
                                : shifted[dfi_pkg::SPAN_W-1:0];
            qq_ff <= {qq_ff[dfi_pkg::FREQ_W-2:0], shifted_ge};
         end else begin
            if (a_ff[dfi_pkg::FREQ_W-1]) begin
               if (sum_ge) begin
                  rr_ff <= sum_sub[dfi_pkg::SPAN_W-1:0];
                  qq_ff <= qq_ff + 1'b1;
               end else begin
                  rr_ff <= sum[dfi_pkg::SPAN_W-1:0];
               end
            end
            a_ff <= {a_ff[dfi_pkg::FREQ_W-2:0], 1'b0};
         end
      end
   end

   assign div_out.done = done_ff;
   assign div_out.q    = qq_ff;
   assign div_out.r    = rr_ff;

endmodule
`default_nettype wire

/* rtl/doppler_frequency_interpolator_top.sv */
// Doppler frequency interpolator: breakpoint table, scan sequencer and output register.
//
// Requests enter on req_* (valid/stall); req_mode selects load (append a
// breakpoint), query (frequency at req_now_ms) or clear. Every request gives
// exactly one response on rsp_* (valid/stall) with result, status and the
// number of breakpoints held. Registers start time and fallback frequency
// are written on csr_* (valid/ready, always ready); the user must write them
// only while the block is idle, and the block itself does not enforce this.
// Load, clear, unused mode and fallback queries answer straight from decode.
// A table query reads one entry per cycle through the memory port, scanning
// k (1..64) entries; it answers directly at the first or last point, after
// a segment check on a zero-length or backward segment, and when it
// interpolates after a serial multiply-divide (a doubling and an adding
// half-step per bit of the 33-bit frequency step), hand-off and rounding.
// One request is worked on at a time; the next is taken the cycle after its
// response has moved into the output register, so a response waiting under
// rsp_stall does not block the next request, but a second finished response
// waits until the first has been taken. Reset empties the table, clears start
// time (table disabled) and sets the fallback to 145.8 MHz; memory is not cleared.
`default_nettype none
`include "doppler_frequency_interpolator_top_macros.svh"
module doppler_frequency_interpolator_top (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  wire  [dfi_pkg::MODE_W-1:0]              req_mode,
   input  wire  signed [dfi_pkg::OFFSET_W-1:0]     req_point_ms,
   input  wire  [dfi_pkg::FREQ_W-1:0]              req_point_hz,
   input  wire  [dfi_pkg::OFFSET_W-1:0]            req_now_ms,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output logic [dfi_pkg::FREQ_W-1:0]              rsp_result_hz,
   output logic [dfi_pkg::STATUS_W-1:0]            rsp_status,
   output logic [dfi_pkg::POINTS_W-1:0]            rsp_points_held,
   input  wire                                     csr_valid,
   output logic                                    csr_ready,
   input  wire  [dfi_pkg::CSR_IDX_W-1:0]           csr_index,
   input  wire  [dfi_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_SEG    = 7'b0001000,
      S_DIV    = 7'b0010000,
      S_ROUND  = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type                              state_ff, state_in;
   logic [dfi_pkg::CNT_W-1:0]              count_ff, count_in;
   logic [dfi_pkg::ADDR_W-1:0]             idx_ff, idx_in;
   logic [dfi_pkg::MODE_W-1:0]             mode_ff;
   logic signed [dfi_pkg::OFFSET_W-1:0]    offset_ff;
   logic [dfi_pkg::FREQ_W-1:0]             freq_ff;
   logic [dfi_pkg::OFFSET_W-1:0]           now_ff;
   logic signed [dfi_pkg::ELAPSED_W-1:0]   elapsed_ff, elapsed_in;
   dfi_pkg::entry_type                     prev_ff, prev_in;
   dfi_pkg::entry_type                     cur_ff, cur_in;
   logic                                   neg_ff, neg_in;
   logic [dfi_pkg::FREQ_W-1:0]             res_hz_ff, res_hz_in;
   logic [dfi_pkg::STATUS_W-1:0]           res_status_ff, res_status_in;
   logic                                   rsp_valid_ff;
   logic [dfi_pkg::FREQ_W-1:0]             rsp_hz_ff;
   logic [dfi_pkg::STATUS_W-1:0]           rsp_status_ff;
   logic [dfi_pkg::POINTS_W-1:0]           rsp_points_ff;
   logic [dfi_pkg::OFFSET_W-1:0]           start_ff;
   logic [dfi_pkg::FREQ_W-1:0]             fallback_ff;

   logic                                   req_accept;
   logic                                   rsp_load;
   logic                                   mem_we;
   logic                                   mem_re;
   logic [dfi_pkg::ADDR_W-1:0]             mem_raddr;
   dfi_pkg::entry_type                     mem_wdata;
   dfi_pkg::entry_type                     mem_rdata;
   dfi_pkg::div_in_type                    div_in;
   dfi_pkg::div_out_type                   div_out;

   logic                                   freq_ok;
   logic                                   scan_hit;
   logic                                   scan_last;
   logic signed [dfi_pkg::ELAPSED_W-1:0]   span_w;
   logic signed [dfi_pkg::NUM_W-1:0]       num_w;
   logic                                   seg_ok;
   logic [dfi_pkg::SPAN_W-1:0]             num_clamped;
   logic                                   neg_w;
   logic [dfi_pkg::FREQ_W-1:0]             step_w;
   logic                                   round_up;
   logic [dfi_pkg::FREQ_W:0]               q_rounded;
   logic [dfi_pkg::FREQ_W:0]               interp_w;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // range check for a load
   assign freq_ok = (freq_ff >= dfi_pkg::FREQ_MIN) && (freq_ff <= dfi_pkg::FREQ_MAX);

   // scan compare against the entry just read
   assign scan_hit  = (elapsed_ff <= $signed({mem_rdata.point_ms[dfi_pkg::OFFSET_W-1],
                                              mem_rdata.point_ms}));
   assign scan_last = ((dfi_pkg::CNT_W'(idx_ff) + 1'b1) == count_ff);

   // segment geometry from the held start and end breakpoints
   assign span_w = $signed({cur_ff.point_ms[dfi_pkg::OFFSET_W-1], cur_ff.point_ms})
                 - $signed({prev_ff.point_ms[dfi_pkg::OFFSET_W-1], prev_ff.point_ms});
   assign num_w  = $signed({elapsed_ff[dfi_pkg::ELAPSED_W-1], elapsed_ff})
                 - $signed({{2{prev_ff.point_ms[dfi_pkg::OFFSET_W-1]}}, prev_ff.point_ms});
   assign seg_ok = (span_w > 0) && (num_w > 0);
   assign num_clamped = (num_w > $signed({span_w[dfi_pkg::ELAPSED_W-1], span_w}))
                      ? span_w[dfi_pkg::SPAN_W-1:0] : num_w[dfi_pkg::SPAN_W-1:0];
   assign neg_w  = (cur_ff.point_hz < prev_ff.point_hz);
   assign step_w = neg_w ? (prev_ff.point_hz - cur_ff.point_hz)
                         : (cur_ff.point_hz - prev_ff.point_hz);

   // round half up on the signed step
   assign round_up  = neg_ff ? ({div_out.r, 1'b0} > {1'b0, span_w[dfi_pkg::SPAN_W-1:0]})
                             : ({div_out.r, 1'b0} >= {1'b0, span_w[dfi_pkg::SPAN_W-1:0]});
   assign q_rounded = {1'b0, div_out.q} + {{dfi_pkg::FREQ_W{1'b0}}, round_up};
   assign interp_w  = neg_ff ? ({1'b0, prev_ff.point_hz} - q_rounded)
                             : ({1'b0, prev_ff.point_hz} + q_rounded);

   assign div_in.start = (state_ff == S_SEG) && seg_ok;
   assign div_in.a     = step_w;
   assign div_in.num   = num_clamped;
   assign div_in.span  = span_w[dfi_pkg::SPAN_W-1:0];

   assign mem_wdata.point_ms = offset_ff;
   assign mem_wdata.point_hz = freq_ff;

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      elapsed_in    = elapsed_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      neg_in        = neg_ff;
      res_hz_in     = res_hz_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_raddr     = idx_ff + 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_hz_in     = '0;
            res_status_in = dfi_pkg::STATUS_REJECTED;
            state_in      = S_DONE;
            elapsed_in    = $signed({1'b0, now_ff}) - $signed({1'b0, start_ff});
            case (mode_ff)
               dfi_pkg::MODE_LOAD: begin
                  if (!freq_ok) begin
                     res_status_in = dfi_pkg::STATUS_REJECTED;
                  end else if (count_ff >= dfi_pkg::CNT_W'(dfi_pkg::TABLE_DEPTH)) begin
                     res_status_in = dfi_pkg::STATUS_FULL;
                  end else begin
                     mem_we        = 1'b1;
                     count_in      = count_ff + 1'b1;
                     res_status_in = dfi_pkg::STATUS_STORED;
                  end
               end
               dfi_pkg::MODE_QUERY: begin
                  if (count_ff == '0 || start_ff == '0) begin
                     res_hz_in     = fallback_ff;
                     res_status_in = dfi_pkg::STATUS_FALLBACK;
                  end else begin
                     res_status_in = dfi_pkg::STATUS_TABLE;
                     mem_re        = 1'b1;
                     mem_raddr     = '0;
                     idx_in        = '0;
                     state_in      = S_SCAN;
                  end
               end
               dfi_pkg::MODE_CLEAR: begin
                  count_in      = '0;
                  res_status_in = dfi_pkg::STATUS_CLEARED;
               end
               default: begin
                  res_status_in = dfi_pkg::STATUS_REJECTED;
               end
            endcase
         end
         S_SCAN: begin
            if (scan_hit) begin
               if (idx_ff == '0) begin
                  res_hz_in = mem_rdata.point_hz;
                  state_in  = S_DONE;
               end else begin
                  cur_in   = mem_rdata;
                  state_in = S_SEG;
               end
            end else begin
               prev_in = mem_rdata;
               if (scan_last) begin
                  res_hz_in = mem_rdata.point_hz;
                  state_in  = S_DONE;
               end else begin
                  mem_re = 1'b1;
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_SEG: begin
            if (seg_ok) begin
               neg_in   = neg_w;
               state_in = S_DIV;
            end else begin
               res_hz_in = prev_ff.point_hz;
               state_in  = S_DONE;
            end
         end
         S_DIV: begin
            if (div_out.done) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            res_hz_in = interp_w[dfi_pkg::FREQ_W-1:0];
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= '0;
         fallback_ff  <= dfi_pkg::FALLBACK_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dfi_pkg::CSR_START_TIME: begin
                  start_ff <= (csr_wdata > dfi_pkg::START_MAX) ? dfi_pkg::START_MAX
                                                               : csr_wdata;
               end
               dfi_pkg::CSR_FALLBACK: begin
                  fallback_ff <= csr_wdata[dfi_pkg::FREQ_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff   <= req_mode;
         offset_ff <= req_point_ms;
         freq_ff   <= req_point_hz;
         now_ff    <= req_now_ms;
      end
      idx_ff        <= idx_in;
      elapsed_ff    <= elapsed_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      neg_ff        <= neg_in;
      res_hz_ff     <= res_hz_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_hz_ff     <= res_hz_ff;
         rsp_status_ff <= res_status_ff;
         rsp_points_ff <= dfi_pkg::POINTS_W'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_hz   = rsp_hz_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_points_held = rsp_points_ff;

   dfi_table_mem u_table_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (count_ff[dfi_pkg::ADDR_W-1:0]),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   dfi_muldiv u_muldiv (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in),
      .div_out (div_out)
   );

   `DFI_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= dfi_pkg::CNT_W'(dfi_pkg::TABLE_DEPTH), "point count above table depth")
   `DFI_ASSERT_IMP(a_write_room, mem_we, count_ff < dfi_pkg::CNT_W'(dfi_pkg::TABLE_DEPTH), "table write with no room")
   `DFI_ASSERT_IMP(a_scan_in_table, state_ff == S_SCAN, dfi_pkg::CNT_W'(idx_ff) < count_ff, "scan beyond held points")
   `DFI_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff == S_DONE), "response loaded outside finish")
   `DFI_ASSERT_NXT(a_div_to_round, state_ff == S_DIV && div_out.done, state_ff == S_ROUND, "divide result not taken")

endmodule
`default_nettype wire

/* tb/tb_doppler_frequency_interpolator_top.sv */
// Self-checking testbench for the doppler frequency interpolator top level.
`timescale 1ns / 100ps
module tb_doppler_frequency_interpolator_top;

   // codes the package does not name
   localparam logic [dfi_pkg::MODE_W-1:0]    MODE_UNUSED = 2'd3;
   localparam logic [dfi_pkg::CSR_IDX_W-1:0] CSR_SPARE   = 2'd3;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [dfi_pkg::MODE_W-1:0]   mode;
      logic [dfi_pkg::OFFSET_W-1:0] point_ms;
      logic [dfi_pkg::FREQ_W-1:0]   point_hz;
      logic [dfi_pkg::OFFSET_W-1:0] now_ms;
   } interp_req_type;

   typedef struct packed {
      logic [dfi_pkg::FREQ_W-1:0]   result_hz;
      logic [dfi_pkg::STATUS_W-1:0] status;
      logic [dfi_pkg::POINTS_W-1:0] points_held;
   } interp_rsp_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [dfi_pkg::MODE_W-1:0]          req_mode = '0;
   logic signed [dfi_pkg::OFFSET_W-1:0] req_point_ms = '0;
   logic [dfi_pkg::FREQ_W-1:0]          req_point_hz = '0;
   logic [dfi_pkg::OFFSET_W-1:0]        req_now_ms = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [dfi_pkg::FREQ_W-1:0]          rsp_result_hz;
   logic [dfi_pkg::STATUS_W-1:0]        rsp_status;
   logic [dfi_pkg::POINTS_W-1:0]        rsp_points_held;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [dfi_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [dfi_pkg::CSR_DATA_W-1:0]      csr_wdata = '0;

   // predicted breakpoint table and registers
   logic signed [dfi_pkg::OFFSET_W-1:0] bp_offset [dfi_pkg::TABLE_DEPTH];
   logic [dfi_pkg::FREQ_W-1:0]          bp_freq [dfi_pkg::TABLE_DEPTH];
   int                                  bp_count = 0;
   logic [dfi_pkg::OFFSET_W-1:0]        sched_start_ms = '0;
   logic [dfi_pkg::FREQ_W-1:0]          fallback_freq_hz = dfi_pkg::FALLBACK_RESET;

   interp_req_type pending_requests [$];
   interp_rsp_type expected_responses [$];
   interp_req_type cur_req;
   int             requests_queued = 0;
   int             mismatch_count = 0;
   int             req_gap = 0;
   int             req_calm = 0;
   int             stall_left = 0;
   int             rsp_calm = 0;
   int             quiet_cycles = 0;

   doppler_frequency_interpolator_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_point_ms    (req_point_ms),
      .req_point_hz    (req_point_hz),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_hz   (rsp_result_hz),
      .rsp_status      (rsp_status),
      .rsp_points_held (rsp_points_held),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [dfi_pkg::OFFSET_W-1:0] rand42();
      return dfi_pkg::OFFSET_W'(rand64());
   endfunction

   function automatic logic [dfi_pkg::FREQ_W-1:0] rand33();
      return dfi_pkg::FREQ_W'(rand64());
   endfunction

   function automatic logic [dfi_pkg::FREQ_W-1:0] rand_freq_ok();
      return dfi_pkg::FREQ_MIN + dfi_pkg::FREQ_W'(rand64() %
             (64'(dfi_pkg::FREQ_MAX - dfi_pkg::FREQ_MIN) + 64'd1));
   endfunction

   function automatic logic [dfi_pkg::FREQ_W-1:0] rand_freq_high();
      return dfi_pkg::FREQ_MAX + dfi_pkg::FREQ_W'(64'd1 + rand64() %
             (64'h1_FFFF_FFFF - 64'(dfi_pkg::FREQ_MAX)));
   endfunction

   // mostly short idle stretches, a few long, and now and then a calm run
   function automatic int idle_length(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 16);
      return $urandom_range(40, 150);
   endfunction

   // linear interpolation over one segment, exact, rounded half up
   function automatic logic [dfi_pkg::FREQ_W-1:0] segment_frequency(
      logic signed [43:0] elapsed, int i);
      logic signed [43:0]         t0, t1, span, num;
      logic [dfi_pkg::FREQ_W-1:0] f0, f1, step;
      logic [127:0]               prod, quot, rem, span_w;
      logic                       falling;
      t0 = bp_offset[i-1];
      t1 = bp_offset[i];
      f0 = bp_freq[i-1];
      f1 = bp_freq[i];
      span = t1 - t0;
      num = elapsed - t0;
      if (span <= 0 || num <= 0) return f0;
      if (num > span) num = span;
      falling = f1 < f0;
      step = falling ? f0 - f1 : f1 - f0;
      span_w = 128'(span);
      prod = 128'(step) * 128'(num);
      quot = prod / span_w;
      rem = prod % span_w;
      if (!falling) begin
         if ((rem << 1) >= span_w) quot++;
         return f0 + quot[dfi_pkg::FREQ_W-1:0];
      end
      if ((rem << 1) > span_w) quot++;
      return f0 - quot[dfi_pkg::FREQ_W-1:0];
   endfunction

   // apply one request to the predicted table and give its response
   function automatic interp_rsp_type frequency_response(interp_req_type rq);
      interp_rsp_type     rs;
      logic signed [43:0] elapsed;
      rs.result_hz = '0;
      rs.status = dfi_pkg::STATUS_REJECTED;
      case (rq.mode)
         dfi_pkg::MODE_LOAD: begin
            if (rq.point_hz < dfi_pkg::FREQ_MIN || rq.point_hz > dfi_pkg::FREQ_MAX) begin
               rs.status = dfi_pkg::STATUS_REJECTED;
            end else if (bp_count >= dfi_pkg::TABLE_DEPTH) begin
               rs.status = dfi_pkg::STATUS_FULL;
            end else begin
               bp_offset[bp_count] = $signed(rq.point_ms);
               bp_freq[bp_count] = rq.point_hz;
               bp_count++;
               rs.status = dfi_pkg::STATUS_STORED;
            end
         end
         dfi_pkg::MODE_QUERY: begin
            if (bp_count == 0 || sched_start_ms == '0) begin
               rs.result_hz = fallback_freq_hz;
               rs.status = dfi_pkg::STATUS_FALLBACK;
            end else begin
               elapsed = $signed({2'b00, rq.now_ms}) - $signed({2'b00, sched_start_ms});
               rs.status = dfi_pkg::STATUS_TABLE;
               if (elapsed <= bp_offset[0]) begin
                  rs.result_hz = bp_freq[0];
               end else begin
                  rs.result_hz = bp_freq[bp_count-1];
                  for (int i = 1; i < bp_count; i++) begin
                     if (elapsed <= bp_offset[i]) begin
                        rs.result_hz = segment_frequency(elapsed, i);
                        break;
                     end
                  end
               end
            end
         end
         dfi_pkg::MODE_CLEAR: begin
            bp_count = 0;
            rs.status = dfi_pkg::STATUS_CLEARED;
         end
         default: ;
      endcase
      rs.points_held = dfi_pkg::POINTS_W'(bp_count);
      return rs;
   endfunction

   task automatic add_request(input logic [dfi_pkg::MODE_W-1:0] mode, input longint off,
                              input logic [dfi_pkg::FREQ_W-1:0] f,
                              input logic [dfi_pkg::OFFSET_W-1:0] now);
      interp_req_type rq;
      rq.mode = mode;
      rq.point_ms = dfi_pkg::OFFSET_W'(off);
      rq.point_hz = f;
      rq.now_ms = now;
      pending_requests.push_back(rq);
      requests_queued++;
   endtask

   // hold until every request has gone in and every response has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || expected_responses.size() != 0 || req_valid);
   endtask

   task automatic write_csr(input logic [dfi_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dfi_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         dfi_pkg::CSR_START_TIME:
            sched_start_ms = (data > dfi_pkg::START_MAX) ? dfi_pkg::START_MAX : data;
         dfi_pkg::CSR_FALLBACK:
            fallback_freq_hz = data[dfi_pkg::FREQ_W-1:0];
         default: ;
      endcase
   endtask

   // request driver: present queued requests with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_responses.push_back(frequency_response(cur_req));
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               cur_req = pending_requests.pop_front();
               req_mode <= cur_req.mode;
               req_point_ms <= cur_req.point_ms;
               req_point_hz <= cur_req.point_hz;
               req_now_ms <= cur_req.now_ms;
               req_valid <= 1'b1;
               req_gap <= idle_length(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: check against the oldest prediction, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected response: result %0d status %0d points %0d",
                           rsp_result_hz, rsp_status, rsp_points_held);
               mismatch_count++;
            end else if (rsp_result_hz !== expected_responses[0].result_hz ||
                         rsp_status !== expected_responses[0].status ||
                         rsp_points_held !== expected_responses[0].points_held) begin
               if (mismatch_count < 10)
                  $display("mismatch at %0t: result %0d/%0d status %0d/%0d points %0d/%0d (exp/act)",
                           $realtime, expected_responses[0].result_hz, rsp_result_hz,
                           expected_responses[0].status, rsp_status,
                           expected_responses[0].points_held, rsp_points_held);
               mismatch_count++;
               void'(expected_responses.pop_front());
            end else begin
               void'(expected_responses.pop_front());
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = idle_length(rsp_calm);
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                   (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                           r, n, m, j;
      longint                       cur, lo, hi, e, width, step, sb;
      logic [dfi_pkg::FREQ_W-1:0]   f;
      logic [dfi_pkg::OFFSET_W-1:0] v;
      longint                       offs [$];

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // defaults: empty table, schedule disabled, range checks
      add_request(dfi_pkg::MODE_QUERY, rand42(), rand33(), '0);
      add_request(dfi_pkg::MODE_QUERY, rand42(), rand33(), '1);
      add_request(dfi_pkg::MODE_LOAD, -(longint'(1) << 41), dfi_pkg::FREQ_MIN - 1, rand42());
      add_request(dfi_pkg::MODE_LOAD, (longint'(1) << 41) - 1, dfi_pkg::FREQ_MIN, rand42());
      add_request(dfi_pkg::MODE_LOAD, 0, dfi_pkg::FREQ_MAX, rand42());
      add_request(dfi_pkg::MODE_LOAD, 5, dfi_pkg::FREQ_MAX + 1, rand42());
      add_request(dfi_pkg::MODE_LOAD, 6, '0, rand42());
      add_request(dfi_pkg::MODE_LOAD, 7, '1, rand42());
      add_request(MODE_UNUSED, rand42(), rand33(), rand42());
      add_request(dfi_pkg::MODE_QUERY, rand42(), rand33(), rand42());
      add_request(dfi_pkg::MODE_CLEAR, rand42(), rand33(), rand42());
      wait_idle();

      // start time saturates, fallback drops the upper data bits
      write_csr(dfi_pkg::CSR_START_TIME, '1);
      write_csr(dfi_pkg::CSR_FALLBACK, {9'h1FF, dfi_pkg::FREQ_MAX});
      sb = longint'(dfi_pkg::START_MAX);
      add_request(dfi_pkg::MODE_QUERY, rand42(), rand33(), dfi_pkg::OFFSET_W'(sb + 10));
      add_request(dfi_pkg::MODE_LOAD, -100, 33'd100_000_000, rand42());
      add_request(dfi_pkg::MODE_LOAD, -98, 33'd100_000_001, rand42());
      add_request(dfi_pkg::MODE_LOAD, -96, 33'd100_000_000, rand42());
      // zero-length segment, then a long rise, a long fall and a backward step
      add_request(dfi_pkg::MODE_LOAD, -96, dfi_pkg::FREQ_MIN, rand42());
      add_request(dfi_pkg::MODE_LOAD, 1000, dfi_pkg::FREQ_MAX, rand42());
      add_request(dfi_pkg::MODE_LOAD, (longint'(1) << 41) - 1, dfi_pkg::FREQ_MIN, rand42());
      add_request(dfi_pkg::MODE_LOAD, -(longint'(1) << 41), dfi_pkg::FREQ_MAX, rand42());
      add_request(dfi_pkg::MODE_QUERY, rand42(), rand33(), '0);
      add_request(dfi_pkg::MODE_QUERY, rand42(), rand33(), dfi_pkg::OFFSET_W'(sb - 99));
      add_request(dfi_pkg::MODE_QUERY, rand42(), rand33(), dfi_pkg::OFFSET_W'(sb - 97));
      add_request(dfi_pkg::MODE_QUERY, rand42(), rand33(), dfi_pkg::OFFSET_W'(sb - 96));
      add_request(dfi_pkg::MODE_QUERY, rand42(), rand33(), dfi_pkg::OFFSET_W'(sb + 500));
      add_request(dfi_pkg::MODE_QUERY, rand42(), rand33(), '1);

      while (requests_queued < 750) begin
         wait_idle();

         // pick new register settings for this stretch
         if ($urandom_range(0, 99) < 70) begin
            r = $urandom_range(0, 99);
            if (r < 15) v = '0;
            else if (r < 25) v = dfi_pkg::START_MAX;
            else if (r < 32)
               v = dfi_pkg::START_MAX + dfi_pkg::OFFSET_W'(64'd1 + rand64() %
                   (64'h3FF_FFFF_FFFF - 64'(dfi_pkg::START_MAX)));
            else v = dfi_pkg::OFFSET_W'(64'd1 + rand64() % 64'(dfi_pkg::START_MAX));
            write_csr(dfi_pkg::CSR_START_TIME, v);
         end
         if ($urandom_range(0, 99) < 50) begin
            r = $urandom_range(0, 99);
            if (r < 15) v = dfi_pkg::OFFSET_W'(dfi_pkg::FREQ_MIN);
            else if (r < 30) v = dfi_pkg::OFFSET_W'(dfi_pkg::FREQ_MAX);
            else if (r < 40) v = rand42();
            else v = dfi_pkg::OFFSET_W'(rand_freq_ok());
            write_csr(dfi_pkg::CSR_FALLBACK, v);
         end
         if ($urandom_range(0, 99) < 5) write_csr(CSR_SPARE, rand42());

         if ($urandom_range(0, 99) < 75) begin
            // well-formed schedule: usually a clear, load a run of points, then query it
            if ($urandom_range(0, 99) < 85)
               add_request(dfi_pkg::MODE_CLEAR, rand42(), rand33(), rand42());
            offs.delete();
            r = $urandom_range(0, 99);
            if (r < 5) n = 1;
            else if (r < 13) n = $urandom_range(60, 70);
            else n = $urandom_range(2, 8);
            r = $urandom_range(0, 99);
            if (r < 70) cur = longint'($urandom_range(0, 2000)) - 1000;
            else if (r < 85) cur = longint'($signed(rand42()));
            else cur = 0;
            f = rand_freq_ok();
            for (j = 0; j < n; j++) begin
               if (j > 0) begin
                  r = $urandom_range(0, 99);
                  if (r < 75) step = $urandom_range(1, 3000);
                  else if (r < 83) step = 0;
                  else if (r < 90) step = -longint'($urandom_range(1, 500));
                  else step = longint'($urandom()) << $urandom_range(0, 8);
                  cur = cur + step;
               end
               r = $urandom_range(0, 99);
               if (r < 10) f = dfi_pkg::FREQ_MIN;
               else if (r < 20) f = dfi_pkg::FREQ_MAX;
               else if (r < 25) f = f;
               else if (r < 28) f = dfi_pkg::FREQ_W'($urandom_range(0, 69_999_999));
               else if (r < 30) f = rand_freq_high();
               else f = rand_freq_ok();
               add_request(dfi_pkg::MODE_LOAD, cur, f, rand42());
               if (f >= dfi_pkg::FREQ_MIN && f <= dfi_pkg::FREQ_MAX) offs.push_back(cur);
               if ($urandom_range(0, 99) < 4)
                  add_request(MODE_UNUSED, rand42(), rand33(), rand42());
            end
            m = $urandom_range(3, 12);
            for (j = 0; j < m; j++) begin
               r = $urandom_range(0, 99);
               if (offs.size() == 0 || r < 10) begin
                  v = rand42();
               end else begin
                  lo = offs[0];
                  hi = offs[offs.size()-1];
                  if (r < 35) begin
                     e = offs[$urandom_range(0, offs.size() - 1)];
                  end else begin
                     width = (hi > lo) ? hi - lo : 0;
                     e = lo - 50 + longint'(rand64() % 64'(width + 101));
                  end
                  v = dfi_pkg::OFFSET_W'(longint'(sched_start_ms) + e);
               end
               add_request(dfi_pkg::MODE_QUERY, rand42(), rand33(), v);
            end
         end else begin
            // noise: any mode, any field values
            n = $urandom_range(10, 20);
            for (j = 0; j < n; j++) begin
               f = ($urandom_range(0, 1) == 0) ? rand33() : rand_freq_ok();
               add_request(dfi_pkg::MODE_W'($urandom_range(0, 3)), longint'(rand42()), f,
                           rand42());
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_responses.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
